>>> design/hist2pk_pkg.sv
// ----------------------------------------------------------------------------
// hist2pk_pkg: shared types and constants of the two-peak finder
// Field widths, register indexes, reset values and the divider status type.
// ----------------------------------------------------------------------------
package hist2pk_pkg;

    // Field widths of the stream payloads and the configuration port.
    localparam int POS_W  = 20;
    localparam int CNT_W  = 32;
    localparam int PCT_W  = 7;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_LOW_LIMIT   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_HIGH_LIMIT  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_EDGE_MIN    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PEAK_SEP    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_WIN_HALF    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_QUALITY_PCT = 3'd5;

    // Register reset values.
    localparam logic [CNT_W-1:0] RST_LOW_LIMIT   = 32'd500;
    localparam logic [CNT_W-1:0] RST_HIGH_LIMIT  = 32'd10000;
    localparam logic [CNT_W-1:0] RST_EDGE_MIN    = 32'd5;
    localparam logic [POS_W-1:0] RST_PEAK_SEP    = 20'd1000;
    localparam logic [POS_W-1:0] RST_WIN_HALF    = 20'd5000;
    localparam logic [PCT_W-1:0] RST_QUALITY_PCT = 7'd20;

    // A bin qualifies when its count times this ratio exceeds the peak count.
    localparam logic [9:0] QUAL_RATIO = 10'd1000;
    // Occupancy is measured in percent.
    localparam logic [6:0] PCT_SCALE  = 7'd100;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> design/hist2pk_div.sv
// ----------------------------------------------------------------------------
// hist2pk_div: shared restoring divider
// Produces one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module hist2pk_div #(
    parameter int N_W = 85,
    parameter int D_W = 45
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [N_W-1:0]         i_dividend,
    input  logic [D_W-1:0]         i_divisor,
    output logic [N_W-1:0]         o_quotient,
    output hist2pk_pkg::t_div_stat o_stat
);
    import hist2pk_pkg::*;

    localparam int KW = $clog2(N_W + 1);

    logic [N_W-1:0] r_q;
    logic [D_W:0]   r_rem;
    logic [D_W-1:0] r_d;
    logic [KW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [D_W:0]   rem_sh;
    logic           take;

    // Shift in the next dividend bit and try the subtraction.
    assign rem_sh = {r_rem[D_W-1:0], r_q[N_W-1]};
    assign take   = rem_sh >= {1'b0, r_d};

    // Iteration control and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= KW'(N_W);
            end else if (r_busy) begin
                r_rem <= take ? (rem_sh - {1'b0, r_d}) : rem_sh;
                r_q   <= {r_q[N_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

>>> design/histogram_two_peak_finder.sv
// ----------------------------------------------------------------------------
// histogram_two_peak_finder: finds one or two peaks in a loaded histogram
// Bins are loaded until a last bin, then a sequencer analyzes the stores.
// ----------------------------------------------------------------------------
// Usage:
// Bins arrive on the slave stream, one beat per cycle while o_s_tready is high;
// tdata holds position and count, tlast marks the final bin of a histogram.
// Bins beyond MAX_BINS are dropped, but a dropped last bin still starts work.
// After the last bin, o_s_tready stays low while a sequencer makes passes over
// the stores through its single read port: a statistics pass and the peak
// search, then for each evaluated peak further passes, two 85-step divisions
// on the shared divider and a square root.
// Results go out on the master stream: one or two beats, tuser is peak_found,
// tlast marks the final beat of the analysis. With no accepted peak a single
// beat with everything zero and tlast set is sent. A stalled receiver simply
// holds the beat; new bins are taken only after the final beat is delivered.
// Reset returns the configuration registers to their defaults and clears the bin count.
// Configuration writes are taken in any cycle through i_cfg_we.
module histogram_two_peak_finder #(
    parameter int MAX_BINS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0 up: bin_position[19:0], bin_count[31:0], zero fill.
    input  logic [55:0]                      i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // Fields from bit 0 up: peak_average[19:0], peak_deviation[19:0].
    output logic [39:0]                      o_m_tdata,
    // Fields from bit 0 up: peak_found.
    output logic                             o_m_tuser,
    output logic                             o_m_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_we,
    input  logic [hist2pk_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [hist2pk_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import hist2pk_pkg::*;

    localparam int AW  = $clog2(MAX_BINS);
    localparam int CW  = $clog2(MAX_BINS + 1);
    localparam int TW  = CNT_W + CW;
    localparam int ACW = 72 + CW;
    localparam int SW  = 23;

    typedef enum logic [3:0] {
        S_LOAD, S_STAT, S_PICK_L, S_PICK_R, S_SEL, S_PK_INIT, S_PASS_A,
        S_DIV_A, S_PASS_B, S_DIV_B, S_SQRT, S_PASS_C, S_QUAL, S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [CNT_W-1:0] r_low_lim, r_high_lim, r_edge_min;
    logic [POS_W-1:0] r_sep, r_win;
    logic [PCT_W-1:0] r_qpct;

    // Bin stores and their registered read data.
    logic [POS_W-1:0] r_pos_mem [MAX_BINS];
    logic [CNT_W-1:0] r_cnt_mem [MAX_BINS];
    logic [POS_W-1:0] r_pos_q;
    logic [CNT_W-1:0] r_cnt_q;

    // Sequencer registers.
    logic [CW-1:0]    r_n, r_idx, r_lowc, r_highc, r_points, r_busy;
    logic [1:0]       r_ph;
    logic [POS_W-1:0] r_spike, r_min_x, r_max_x;
    logic             r_found;
    logic signed [SW-1:0] r_middle, r_lo, r_hi;
    logic [POS_W-1:0] r_lpos, r_rpos;
    logic [CNT_W-1:0] r_lcnt, r_rcnt;
    logic [POS_W-1:0] r_pk_pos [2];
    logic [CNT_W-1:0] r_pk_cnt [2];
    logic [1:0]       r_npk;
    logic             r_pk_i;
    logic [POS_W-1:0] r_ppos;
    logic [CNT_W-1:0] r_pcnt;
    logic             r_qual;
    logic [39:0]      r_mul_a;
    logic [ACW-1:0]   r_acc;
    logic [TW-1:0]    r_total;
    logic [POS_W-1:0] r_avg, r_dev;
    logic [63:0]      r_sq_v, r_sq_res, r_sq_bit;
    logic [POS_W-1:0] r_ravg [2];
    logic [POS_W-1:0] r_rdev [2];
    logic [1:0]       r_k;
    logic             r_out_i;
    logic             r_div_start;
    logic             r_m_valid, r_m_found, r_m_last;
    logic [POS_W-1:0] r_m_avg, r_m_dev;

    // Combinational helpers.
    logic [POS_W-1:0]     in_pos;
    logic [CNT_W-1:0]     in_cnt;
    logic                 in_beat;
    logic signed [SW-1:0] pos_s, diff_mm, avg_s, dev_s;
    logic [41:0]          cnt_scaled;
    logic                 in_win;
    logic [POS_W-1:0]     abs_d;
    logic [39:0]          abs_sq;
    logic [55:0]          prod;
    logic [63:0]          sq_try;
    logic [39:0]          busy_pct, need_pct;
    logic [ACW-1:0]       quot;
    t_div_stat            div_stat;

    assign in_pos  = i_s_tdata[POS_W-1:0];
    assign in_cnt  = i_s_tdata[POS_W+CNT_W-1:POS_W];
    assign in_beat = i_s_tvalid && o_s_tready;

    // Window test for the bin under the read port.
    assign pos_s      = $signed({3'b000, r_pos_q});
    assign cnt_scaled = 42'(r_cnt_q) * 42'(QUAL_RATIO);
    assign in_win     = (pos_s >= r_lo) && (pos_s <= r_hi) && (cnt_scaled > 42'(r_pcnt));

    // Middle mark from the populated range: half its width, rounded toward zero when positive.
    assign diff_mm = $signed({3'b000, r_max_x}) - $signed({3'b000, r_min_x});

    // Squared distance to the mean and the shared half-width product.
    assign abs_d  = (r_pos_q >= r_avg) ? (r_pos_q - r_avg) : (r_avg - r_pos_q);
    assign abs_sq = 40'(abs_d) * 40'(abs_d);
    assign prod   = 56'(r_mul_a) * 56'(r_ph[0] ? r_cnt_q[31:16] : r_cnt_q[15:0]);

    // Square root step and occupancy test.
    assign sq_try   = r_sq_res + r_sq_bit;
    assign avg_s    = $signed({3'b000, r_avg});
    assign dev_s    = $signed({3'b000, r_dev});
    assign busy_pct = 40'(r_busy) * 40'(PCT_SCALE);
    assign need_pct = 40'(r_qpct) * (40'(r_dev) * 40'd2 + 40'd1);

    hist2pk_div #(
        .N_W(ACW),
        .D_W(TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_total),
        .o_quotient (quot),
        .o_stat     (div_stat)
    );

    // Bin stores: written while loading, read at the scan index.
    always_ff @(posedge i_clk) begin
        if (in_beat && (r_n < CW'(MAX_BINS))) begin
            r_pos_mem[r_n[AW-1:0]] <= in_pos;
            r_cnt_mem[r_n[AW-1:0]] <= in_cnt;
        end
        r_pos_q <= r_pos_mem[r_idx[AW-1:0]];
        r_cnt_q <= r_cnt_mem[r_idx[AW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_lim  <= RST_LOW_LIMIT;
            r_high_lim <= RST_HIGH_LIMIT;
            r_edge_min <= RST_EDGE_MIN;
            r_sep      <= RST_PEAK_SEP;
            r_win      <= RST_WIN_HALF;
            r_qpct     <= RST_QUALITY_PCT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOW_LIMIT:   r_low_lim  <= i_cfg_wdata;
                CFG_HIGH_LIMIT:  r_high_lim <= i_cfg_wdata;
                CFG_EDGE_MIN:    r_edge_min <= i_cfg_wdata;
                CFG_PEAK_SEP:    r_sep      <= i_cfg_wdata[POS_W-1:0];
                CFG_WIN_HALF:    r_win      <= i_cfg_wdata[POS_W-1:0];
                CFG_QUALITY_PCT: r_qpct     <= i_cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: loading, analysis passes and result delivery.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= '0;
            r_idx       <= '0;
            r_ph        <= '0;
            r_k         <= '0;
            r_out_i     <= 1'b0;
            r_div_start <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                // Take bins until the last one.
                S_LOAD: begin
                    if (in_beat) begin
                        if (r_n < CW'(MAX_BINS)) begin
                            r_n <= r_n + 1'b1;
                        end
                        if (i_s_tlast) begin
                            r_state <= S_STAT;
                            r_idx   <= '0;
                            r_ph    <= '0;
                            r_lowc  <= '0;
                            r_highc <= '0;
                            r_found <= 1'b0;
                            r_k     <= '0;
                            r_out_i <= 1'b0;
                        end
                    end
                end

                // Count low and high bins and find the populated range; a lone high bin is sent directly.
                S_STAT: begin
                    if (r_ph == 2'd0) begin
                        if (r_idx == r_n) begin
                            if ((r_n != '0) && ((CW+1)'(r_lowc) + (CW+1)'(r_highc)
                                    == (CW+1)'(r_n)) && (r_highc == CW'(1))) begin
                                r_k       <= 2'd1;
                                r_ravg[0] <= r_spike;
                                r_rdev[0] <= '0;
                                r_state   <= S_OUT;
                            end else if (!r_found) begin
                                r_state <= S_OUT;
                            end else begin
                                r_middle <= (diff_mm + $signed(SW'(diff_mm[SW-1]))) >>> 1;
                                r_idx    <= '0;
                                r_state  <= S_PICK_L;
                            end
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        if (r_cnt_q < r_low_lim) begin
                            r_lowc <= r_lowc + 1'b1;
                        end else if (r_cnt_q > r_high_lim) begin
                            r_highc <= r_highc + 1'b1;
                            r_spike <= r_pos_q;
                        end
                        if (r_cnt_q >= r_edge_min) begin
                            if (!r_found) begin
                                r_min_x <= r_pos_q;
                            end
                            r_max_x <= r_pos_q;
                            r_found <= 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                        r_ph  <= 2'd0;
                    end
                end

                // Largest bin below the middle mark.
                S_PICK_L: begin
                    if (r_ph == 2'd0) begin
                        if (r_idx == r_n) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        r_ph  <= 2'd0;
                        r_idx <= r_idx + 1'b1;
                        if ((r_idx == '0) || ((pos_s < r_middle) && (r_cnt_q > r_lcnt))) begin
                            r_lpos <= r_pos_q;
                            r_lcnt <= r_cnt_q;
                        end
                        if (pos_s >= r_middle) begin
                            r_rpos  <= r_pos_q;
                            r_rcnt  <= r_cnt_q;
                            r_state <= S_PICK_R;
                        end
                    end
                end

                // Largest bin from the middle mark up to the range end.
                S_PICK_R: begin
                    if (r_ph == 2'd0) begin
                        if (r_idx == r_n) begin
                            r_state <= S_SEL;
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        r_ph <= 2'd0;
                        if (r_pos_q <= r_max_x) begin
                            if (r_cnt_q > r_rcnt) begin
                                r_rpos <= r_pos_q;
                                r_rcnt <= r_cnt_q;
                            end
                            r_idx <= r_idx + 1'b1;
                        end else begin
                            r_state <= S_SEL;
                        end
                    end
                end

                // One merged peak or two separate ones.
                S_SEL: begin
                    r_pk_i <= 1'b0;
                    r_state <= S_PK_INIT;
                    if ({1'b0, r_rpos} < ({1'b0, r_lpos} + {1'b0, r_sep})) begin
                        r_npk <= 2'd1;
                        r_pk_pos[0] <= (r_rcnt > r_lcnt) ? r_rpos : r_lpos;
                        r_pk_cnt[0] <= (r_rcnt > r_lcnt) ? r_rcnt : r_lcnt;
                    end else begin
                        r_npk <= 2'd2;
                        r_pk_pos[0] <= r_lpos;
                        r_pk_cnt[0] <= r_lcnt;
                        r_pk_pos[1] <= r_rpos;
                        r_pk_cnt[1] <= r_rcnt;
                    end
                end

                // Window of the current peak; the clip at the middle mark follows in the first pass.
                S_PK_INIT: begin
                    r_ppos   <= r_pk_pos[r_pk_i];
                    r_pcnt   <= r_pk_cnt[r_pk_i];
                    r_lo     <= $signed({3'b000, r_pk_pos[r_pk_i]}) - $signed({3'b000, r_win});
                    r_hi     <= $signed({3'b000, r_pk_pos[r_pk_i]}) + $signed({3'b000, r_win});
                    r_acc    <= '0;
                    r_total  <= '0;
                    r_points <= '0;
                    r_idx    <= '0;
                    r_ph     <= '0;
                    r_state  <= S_PASS_A;
                end

                // Weighted sum of positions, total count and points over qualifying bins.
                S_PASS_A: begin
                    case (r_ph)
                        2'd0: begin
                            if ((r_idx == '0) && ($signed({3'b000, r_ppos}) > r_middle)
                                    && (r_lo < r_middle)) begin
                                r_lo <= r_middle;
                            end
                            if ((r_idx == '0) && ($signed({3'b000, r_ppos}) < r_middle)
                                    && (r_hi > r_middle)) begin
                                r_hi <= r_middle;
                            end
                            if (r_idx == r_n) begin
                                if ((r_points < CW'(2)) || (r_total == '0)) begin
                                    r_state <= S_QUAL;
                                    r_qual  <= 1'b0;
                                end else begin
                                    r_div_start <= 1'b1;
                                    r_state     <= S_DIV_A;
                                end
                            end else begin
                                r_ph <= 2'd1;
                            end
                        end
                        2'd1: begin
                            r_mul_a <= 40'(r_pos_q);
                            if (in_win) begin
                                r_ph <= 2'd2;
                            end else begin
                                r_ph  <= 2'd0;
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                        2'd2: begin
                            r_acc <= r_acc + ACW'(prod);
                            r_ph  <= 2'd3;
                        end
                        default: begin
                            r_acc    <= r_acc + (ACW'(prod) << 16);
                            r_total  <= r_total + TW'(r_cnt_q);
                            r_points <= r_points + 1'b1;
                            r_idx    <= r_idx + 1'b1;
                            r_ph     <= 2'd0;
                        end
                    endcase
                end

                // Mean position.
                S_DIV_A: begin
                    if (div_stat.done) begin
                        r_avg   <= quot[POS_W-1:0];
                        r_acc   <= '0;
                        r_idx   <= '0;
                        r_ph    <= '0;
                        r_state <= S_PASS_B;
                    end
                end

                // Weighted sum of squared distances to the mean.
                S_PASS_B: begin
                    case (r_ph)
                        2'd0: begin
                            if (r_idx == r_n) begin
                                r_div_start <= 1'b1;
                                r_state     <= S_DIV_B;
                            end else begin
                                r_ph <= 2'd1;
                            end
                        end
                        2'd1: begin
                            r_mul_a <= abs_sq;
                            if (in_win) begin
                                r_ph <= 2'd2;
                            end else begin
                                r_ph  <= 2'd0;
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                        2'd2: begin
                            r_acc <= r_acc + ACW'(prod);
                            r_ph  <= 2'd3;
                        end
                        default: begin
                            r_acc <= r_acc + (ACW'(prod) << 16);
                            r_idx <= r_idx + 1'b1;
                            r_ph  <= 2'd0;
                        end
                    endcase
                end

                // Variance, then the square root.
                S_DIV_B: begin
                    if (div_stat.done) begin
                        r_sq_v   <= quot[63:0];
                        r_sq_res <= '0;
                        r_sq_bit <= 64'd1 << 62;
                        r_state  <= S_SQRT;
                    end
                end

                // One result bit per step.
                S_SQRT: begin
                    if (r_sq_bit == '0) begin
                        r_dev   <= r_sq_res[POS_W-1:0];
                        r_busy  <= '0;
                        r_idx   <= '0;
                        r_ph    <= '0;
                        r_state <= S_PASS_C;
                    end else begin
                        if (r_sq_v >= sq_try) begin
                            r_sq_v   <= r_sq_v - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end

                // Bins within one deviation of the mean.
                S_PASS_C: begin
                    if (r_ph == 2'd0) begin
                        if (r_idx == r_n) begin
                            r_qual  <= 1'b1;
                            r_state <= S_QUAL;
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        if ((pos_s >= avg_s - dev_s) && (pos_s <= avg_s + dev_s)) begin
                            r_busy <= r_busy + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                        r_ph  <= 2'd0;
                    end
                end

                // Keep the peak if it passed, then go on to the next one.
                S_QUAL: begin
                    if (r_qual && !(busy_pct < need_pct)) begin
                        r_ravg[r_k[0]] <= r_avg;
                        r_rdev[r_k[0]] <= r_dev;
                        r_k            <= r_k + 1'b1;
                    end
                    if ((r_npk == 2'd2) && !r_pk_i) begin
                        r_pk_i  <= 1'b1;
                        r_state <= S_PK_INIT;
                    end else begin
                        r_out_i <= 1'b0;
                        r_state <= S_OUT;
                    end
                end

                // Deliver the result beats.
                S_OUT: begin
                    if (!r_m_valid) begin
                        r_m_valid <= 1'b1;
                        r_m_found <= (r_k != '0);
                        r_m_avg   <= (r_k != '0) ? r_ravg[r_out_i] : '0;
                        r_m_dev   <= (r_k != '0) ? r_rdev[r_out_i] : '0;
                        r_m_last  <= (r_k == '0) || ({1'b0, r_out_i} == r_k - 1'b1);
                    end else if (i_m_tready) begin
                        r_m_valid <= 1'b0;
                        if (r_m_last) begin
                            r_n     <= '0;
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_out_i <= 1'b1;
                        end
                    end
                end

                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_found;
    assign o_m_tlast  = r_m_last;
    assign o_m_tdata  = {r_m_dev, r_m_avg};

`ifndef NO_ASSERTIONS
    // Loading and delivery never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("bins accepted while a result is pending");

    // A beat without a peak is always the only and final beat.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("empty result is not a lone final beat");

    // The fill count never passes the store depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_BINS))
        else $error("bin count beyond store depth");

    // The last beat taken sends the block back to loading.
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("block did not return to loading");
`endif

endmodule
